FILE: hdl/assert_macros.svh
// Concurrent assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/oaht_pkg.sv
// Shared widths, codes, control word types and the microcode ROM.
`default_nettype none

package oaht_pkg;

    localparam int KeyW         = 31;
    localparam int PayloadW     = 64;
    localparam int StatusW      = 2;
    localparam int SlotW        = 10;
    localparam int DefTableSize = 19;

    // operation codes
    localparam logic FnInsert = 1'b0;
    localparam logic FnSearch = 1'b1;

    // result status codes
    localparam logic [StatusW-1:0] StOk       = 2'd0;
    localparam logic [StatusW-1:0] StNotFound = 2'd1;
    localparam logic [StatusW-1:0] StFull     = 2'd2;
    localparam logic [StatusW-1:0] StZeroKey  = 2'd3;

    // microprogram addresses
    localparam int PcW = 3;
    localparam logic [PcW-1:0] StepClear = 3'd0;
    localparam logic [PcW-1:0] StepIdle  = 3'd1;
    localparam logic [PcW-1:0] StepHash1 = 3'd2;
    localparam logic [PcW-1:0] StepHash2 = 3'd3;
    localparam logic [PcW-1:0] StepHash3 = 3'd4;
    localparam logic [PcW-1:0] StepRead  = 3'd5;
    localparam logic [PcW-1:0] StepEval  = 3'd6;
    localparam logic [PcW-1:0] StepFin   = 3'd7;

    // jump conditions
    localparam int CondW = 3;
    localparam logic [CondW-1:0] CondNever     = 3'd0;
    localparam logic [CondW-1:0] CondAccept    = 3'd1;
    localparam logic [CondW-1:0] CondClrLast   = 3'd2;
    localparam logic [CondW-1:0] CondZeroKey   = 3'd3;
    localparam logic [CondW-1:0] CondProbeMore = 3'd4;
    localparam logic [CondW-1:0] CondOutFree   = 3'd5;

    // datapath strobes of one control word
    typedef struct packed {
        logic take;     // request channel ready
        logic clr_wr;   // write an empty key, step the slot index
        logic mul1;     // key times reciprocal
        logic mul2;     // quotient times table size
        logic ld_home;  // load home slot, zero the probe count
        logic rd;       // read the slot stores
        logic probe;    // evaluate the slot just read
        logic out_ld;   // move the result to the response register
    } dp_ctl_t;

    typedef struct packed {
        dp_ctl_t         dp;
        logic [CondW-1:0] cond;
        logic [PcW-1:0]   target;
        logic             stay;   // hold the step when the condition fails
    } uword_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic clr_last;
        logic zero_key;
        logic probe_more;
        logic out_free;
    } dp_stat_t;

    function automatic uword_t ucode(input logic [PcW-1:0] pc);
        uword_t w;
        w = '0;
        case (pc)
            StepClear:
            begin
                w.dp.clr_wr = 1'b1;
                w.cond      = CondClrLast;
                w.target    = StepIdle;
                w.stay      = 1'b1;
            end
            StepIdle:
            begin
                w.dp.take = 1'b1;
                w.cond    = CondAccept;
                w.target  = StepHash1;
                w.stay    = 1'b1;
            end
            StepHash1:
            begin
                w.dp.mul1 = 1'b1;
                w.cond    = CondZeroKey;
                w.target  = StepFin;
            end
            StepHash2:
            begin
                w.dp.mul2 = 1'b1;
            end
            StepHash3:
            begin
                w.dp.ld_home = 1'b1;
            end
            StepRead:
            begin
                w.dp.rd = 1'b1;
            end
            StepEval:
            begin
                w.dp.probe = 1'b1;
                w.cond     = CondProbeMore;
                w.target   = StepRead;
            end
            StepFin:
            begin
                w.dp.out_ld = 1'b1;
                w.cond      = CondOutFree;
                w.target    = StepIdle;
                w.stay      = 1'b1;
            end
            default:
            begin
                w.cond   = CondNever;
                w.target = StepIdle;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/oaht_ifs.sv
// Request and response channel interfaces.
`default_nettype none

interface oaht_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [oaht_pkg::KeyW-1:0]     key;
    logic [oaht_pkg::PayloadW-1:0] payload;

    modport source (output valid, output func, output key, output payload, input ready);
    modport sink (input valid, input func, input key, input payload, output ready);
endinterface

interface oaht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [oaht_pkg::StatusW-1:0]  status;
    logic [oaht_pkg::SlotW-1:0]    slot;
    logic [oaht_pkg::PayloadW-1:0] found_payload;

    modport source (output valid, output status, output slot, output found_payload,
                    input ready);
    modport sink (input valid, input status, input slot, input found_payload,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/oaht_hash.sv
// Home slot unit: key modulo table size by reciprocal multiply and one correction.
`default_nettype none

module oaht_hash #(
    parameter int TableSize = oaht_pkg::DefTableSize
) (
    input  wire logic                                clk,
    input  wire logic                                mul1,
    input  wire logic                                mul2,
    input  wire logic [oaht_pkg::KeyW-1:0]           key,
    output logic      [$clog2(TableSize)-1:0]        home
);

    localparam int KeyW = oaht_pkg::KeyW;
    localparam int IdxW = $clog2(TableSize);
    localparam int ProdW = 2 * KeyW;
    // floor(2^KeyW / N): the estimated quotient is low by at most one
    localparam logic [KeyW-1:0] Recip   = KeyW'((64'd1 << KeyW) / TableSize);
    localparam logic [KeyW-1:0] Modulus = KeyW'(TableSize);

    logic [ProdW-1:0] prod_reg;
    logic [KeyW-1:0]  back_reg;
    logic [KeyW-1:0]  quot;
    logic [KeyW-1:0]  diff;
    logic [KeyW-1:0]  rem;

    assign quot = prod_reg[ProdW-1:KeyW];

    always_ff @(posedge clk)
    begin
        if (mul1)
        begin
            prod_reg <= ProdW'(key) * ProdW'(Recip);
        end
        if (mul2)
        begin
            back_reg <= KeyW'(quot * Modulus);
        end
    end

    // remainder lies below twice the table size
    always_comb
    begin
        diff = key - back_reg;
        rem  = (diff >= Modulus) ? (diff - Modulus) : diff;
        home = IdxW'(rem);
    end

endmodule

`default_nettype wire

FILE: hdl/oaht_seq.sv
// Microprogram sequencer: step counter, control ROM and conditional jumps.
`default_nettype none

module oaht_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire oaht_pkg::dp_stat_t stat,
    output oaht_pkg::dp_ctl_t       ctl
);

    logic [oaht_pkg::PcW-1:0] pc_reg;
    logic [oaht_pkg::PcW-1:0] pc_next;
    oaht_pkg::uword_t         word;
    logic                     jump;

    assign word = oaht_pkg::ucode(pc_reg);
    assign ctl  = word.dp;

    always_comb
    begin
        case (word.cond)
            oaht_pkg::CondNever:     jump = 1'b0;
            oaht_pkg::CondAccept:    jump = accept;
            oaht_pkg::CondClrLast:   jump = stat.clr_last;
            oaht_pkg::CondZeroKey:   jump = stat.zero_key;
            oaht_pkg::CondProbeMore: jump = stat.probe_more;
            oaht_pkg::CondOutFree:   jump = stat.out_free;
            default:                 jump = 1'b0;
        endcase

        if (jump)
        begin
            pc_next = word.target;
        end
        else if (word.stay)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= oaht_pkg::StepClear;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/oaht_dpath.sv
// Datapath: item registers, slot stores, probe logic and response register.
`default_nettype none

module oaht_dpath #(
    parameter int TableSize = oaht_pkg::DefTableSize
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire oaht_pkg::dp_ctl_t                 ctl,
    input  wire logic                              accept,
    input  wire logic                              func,
    input  wire logic [oaht_pkg::KeyW-1:0]         key,
    input  wire logic [oaht_pkg::PayloadW-1:0]     payload,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic      [oaht_pkg::StatusW-1:0]      status,
    output logic      [oaht_pkg::SlotW-1:0]        slot,
    output logic      [oaht_pkg::PayloadW-1:0]     found_payload,
    output oaht_pkg::dp_stat_t                     stat
);

    localparam int KeyW     = oaht_pkg::KeyW;
    localparam int PayloadW = oaht_pkg::PayloadW;
    localparam int StatusW  = oaht_pkg::StatusW;
    localparam int SlotW    = oaht_pkg::SlotW;
    localparam int IdxW     = $clog2(TableSize);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSize - 1);

    // item registers
    logic                func_reg;
    logic [KeyW-1:0]     key_reg;
    logic [PayloadW-1:0] payload_reg;

    // probe position
    logic [IdxW-1:0] idx_reg;
    logic [IdxW-1:0] idx_next;
    logic [IdxW-1:0] cnt_reg;
    logic [IdxW-1:0] cnt_next;
    logic [IdxW-1:0] home;

    // slot stores and their read registers
    logic [KeyW-1:0]     key_mem [TableSize];
    logic [PayloadW-1:0] pay_mem [TableSize];
    logic [KeyW-1:0]     rkey_reg;
    logic [PayloadW-1:0] rpay_reg;

    // pending result and response register
    logic [StatusW-1:0]  res_status_reg;
    logic [SlotW-1:0]    res_slot_reg;
    logic [PayloadW-1:0] res_pay_reg;
    logic                out_valid_reg;
    logic [StatusW-1:0]  out_status_reg;
    logic [SlotW-1:0]    out_slot_reg;
    logic [PayloadW-1:0] out_pay_reg;

    logic idx_last;
    logic slot_empty;
    logic key_hit;
    logic probe_done;
    logic key_we;
    logic pay_we;
    logic out_free;
    logic [IdxW-1:0] idx_step;

    oaht_hash #(
        .TableSize (TableSize)
    ) u_hash (
        .clk  (clk),
        .mul1 (ctl.mul1),
        .mul2 (ctl.mul2),
        .key  (key_reg),
        .home (home)
    );

    always_comb
    begin
        idx_last   = (idx_reg == LastIdx);
        idx_step   = idx_last ? '0 : (idx_reg + 1'b1);
        slot_empty = (rkey_reg == '0);
        key_hit    = (func_reg == oaht_pkg::FnSearch) && (rkey_reg == key_reg);
        probe_done = slot_empty || key_hit || (cnt_reg == LastIdx);
        key_we     = ctl.clr_wr
                     || (ctl.probe && (func_reg == oaht_pkg::FnInsert) && slot_empty);
        pay_we     = ctl.probe && (func_reg == oaht_pkg::FnInsert) && slot_empty;
        out_free   = !out_valid_reg || out_ready;

        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (ctl.ld_home)
        begin
            idx_next = home;
            cnt_next = '0;
        end
        else if (ctl.clr_wr)
        begin
            idx_next = idx_step;
        end
        else if (ctl.probe && !probe_done)
        begin
            idx_next = idx_step;
            cnt_next = cnt_reg + 1'b1;
        end

        stat.clr_last   = idx_last;
        stat.zero_key   = (key_reg == '0);
        stat.probe_more = !probe_done;
        stat.out_free   = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            if (ctl.out_ld && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // latch the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            key_reg     <= key;
            payload_reg <= payload;
        end
    end

    // slot stores: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[idx_reg] <= ctl.clr_wr ? '0 : key_reg;
        end
        if (pay_we)
        begin
            pay_mem[idx_reg] <= payload_reg;
        end
        if (ctl.rd)
        begin
            rkey_reg <= key_mem[idx_reg];
            rpay_reg <= pay_mem[idx_reg];
        end
    end

    // build the result, then hand it to the response register
    always_ff @(posedge clk)
    begin
        if (ctl.mul1 && (key_reg == '0))
        begin
            res_status_reg <= oaht_pkg::StZeroKey;
            res_slot_reg   <= '0;
            res_pay_reg    <= '0;
        end
        else if (ctl.probe && probe_done)
        begin
            if ((func_reg == oaht_pkg::FnInsert) && slot_empty)
            begin
                res_status_reg <= oaht_pkg::StOk;
                res_slot_reg   <= SlotW'(idx_reg);
                res_pay_reg    <= '0;
            end
            else if (func_reg == oaht_pkg::FnInsert)
            begin
                res_status_reg <= oaht_pkg::StFull;
                res_slot_reg   <= '0;
                res_pay_reg    <= '0;
            end
            else if (key_hit)
            begin
                res_status_reg <= oaht_pkg::StOk;
                res_slot_reg   <= SlotW'(idx_reg);
                res_pay_reg    <= rpay_reg;
            end
            else
            begin
                res_status_reg <= oaht_pkg::StNotFound;
                res_slot_reg   <= '0;
                res_pay_reg    <= '0;
            end
        end

        if (ctl.out_ld && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_pay_reg    <= res_pay_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot          = out_slot_reg;
    assign found_payload = out_pay_reg;

endmodule

`default_nettype wire

FILE: hdl/open_address_hash_table.sv
// Top level of the linear-probing hash table.
//
//  channel | role | payload                          | item
//  --------+------+----------------------------------+-------------------------------
//  req     | sink | func, key, payload               | one insert or search
//  rsp     | src  | status, slot, found_payload      | one answer per request item
//
// An accepted item runs the hash steps, then probes 1 to TableSize slots, each
// probe a read step and an evaluate step on the single port of the slot stores,
// before its answer moves to the response register. A zero key goes from the
// first hash step straight to the final step. After reset the microprogram first
// sweeps the key store to empty, one slot a cycle; req.ready stays low until done.
// A stalled rsp holds the finished answer; the next request item may be accepted
// meanwhile, and its answer waits in the final step until the register frees up.
`default_nettype none
`include "assert_macros.svh"

module open_address_hash_table #(
    parameter int TableSize = oaht_pkg::DefTableSize
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    oaht_req_if.sink    req,
    oaht_rsp_if.source  rsp
);

    oaht_pkg::dp_ctl_t  ctl;
    oaht_pkg::dp_stat_t stat;
    logic               accept;

    // the request channel is open only in the idle step of the microprogram
    assign req.ready = ctl.take;
    assign accept    = req.valid && ctl.take;

    // step counter and control ROM
    oaht_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .stat   (stat),
        .ctl    (ctl)
    );

    // hash, slot stores, probe evaluation, response register
    oaht_dpath #(
        .TableSize (TableSize)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .accept        (accept),
        .func          (req.func),
        .key           (req.key),
        .payload       (req.payload),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .status        (rsp.status),
        .slot          (rsp.slot),
        .found_payload (rsp.found_payload),
        .stat          (stat)
    );

    // an accepted item always enters the hash steps next
    `ASSERT_NEXT(a_accept_to_hash, clk, rst_n, accept, ctl.mul1)
    // a finished probe goes straight to the answer step
    `ASSERT_NEXT(a_probe_to_fin, clk, rst_n, ctl.probe && !stat.probe_more, ctl.out_ld)
    // a new answer appears only from the answer step
    `ASSERT_IMPLY(a_rsp_from_fin, clk, rst_n, $rose(rsp.valid), $past(ctl.out_ld))

endmodule

`default_nettype wire

FILE: tb/open_address_hash_table_test.sv
// Self-checking testbench for the linear-probing hash table: random handshakes, live mirror.
module open_address_hash_table_test;

    localparam int KeyW        = oaht_pkg::KeyW;
    localparam int PayloadW    = oaht_pkg::PayloadW;
    localparam int StatusW     = oaht_pkg::StatusW;
    localparam int SlotW       = oaht_pkg::SlotW;
    localparam int TableSize   = oaht_pkg::DefTableSize;
    localparam int RandomItems = 800;
    // Pad the tail past the slowest item, one that probes every slot.
    localparam int DrainCycles = 5 + 2 * TableSize + 20;
    localparam int HoldAfter   = 300;
    localparam int HoldCycles  = 300;
    localparam int CycleLimit  = 400000;

    localparam logic [KeyW-1:0] KeyMax = {KeyW{1'b1}};

    typedef struct packed {
        logic                func;
        logic [KeyW-1:0]     key;
        logic [PayloadW-1:0] payload;
    } request_t;

    typedef struct packed {
        logic [StatusW-1:0]  status;
        logic [SlotW-1:0]    slot;
        logic [PayloadW-1:0] found_payload;
    } answer_t;

    // One outstanding lookup: the request as accepted and the answer it must produce.
    typedef struct packed {
        request_t req;
        answer_t  ans;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n;

    oaht_req_if req ();
    oaht_rsp_if rsp ();

    open_address_hash_table #(
        .TableSize(TableSize)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    // Mirror of the slot stores, updated in acceptance order.
    logic [KeyW-1:0]     mirror_keys     [TableSize] = '{default: '0};
    logic [PayloadW-1:0] mirror_payloads [TableSize] = '{default: '0};

    request_t pending_requests [$];
    lookup_t  expected_answers [$];
    logic [KeyW-1:0] planned_keys [$];   // keys the stimulus has sent for insertion

    request_t in_flight;
    lookup_t  new_lookup;
    lookup_t  oldest_lookup;
    logic     offering;
    int       send_gap;
    int       recv_gap;
    int       items_accepted;
    int       answers_seen;
    int       total_requests;
    int       hold_left;
    logic     hold_done;
    int       cycle_count;
    int       error_count;

    // What the run exercised, tallied when each answer is predicted.
    int stored_count;
    int full_count;
    int hit_count;
    int miss_count;
    int zero_key_count;

    always #1 clk = ~clk;

    // Walk the probe path of one request against the mirror and return its answer.
    // Inserts claim the first empty slot; searches stop at a match or an empty slot.
    function automatic answer_t probe_table(input request_t r);
        answer_t     a;
        int unsigned idx;
        int unsigned n;
        a = '0;
        if (r.key == '0)
        begin
            a.status = oaht_pkg::StZeroKey;
            zero_key_count++;
            return a;
        end
        idx = int'(r.key) % TableSize;
        if (r.func == oaht_pkg::FnInsert)
        begin
            for (n = 0; n < TableSize; n++)
            begin
                if (mirror_keys[idx] == '0)
                begin
                    mirror_keys[idx]     = r.key;
                    mirror_payloads[idx] = r.payload;
                    a.status = oaht_pkg::StOk;
                    a.slot   = SlotW'(idx);
                    stored_count++;
                    return a;
                end
                idx = (idx + 1 == TableSize) ? 0 : idx + 1;
            end
            a.status = oaht_pkg::StFull;
            full_count++;
            return a;
        end
        for (n = 0; n < TableSize; n++)
        begin
            if (mirror_keys[idx] == '0)
                break;
            if (mirror_keys[idx] == r.key)
            begin
                a.status        = oaht_pkg::StOk;
                a.slot          = SlotW'(idx);
                a.found_payload = mirror_payloads[idx];
                hit_count++;
                return a;
            end
            idx = (idx + 1 == TableSize) ? 0 : idx + 1;
        end
        a.status = oaht_pkg::StNotFound;
        miss_count++;
        return a;
    endfunction

    // Draw a random wait; every third run of 50 items goes without waits.
    // The side offset keeps the two ends from bursting at the same time.
    function automatic int pause_cycles(input int count, input int side);
        if (((count / 50) + side) % 3 == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic void queue_request(input logic f, input logic [KeyW-1:0] k,
                                          input logic [PayloadW-1:0] p);
        request_t r;
        r.func    = f;
        r.key     = k;
        r.payload = p;
        pending_requests.push_back(r);
        if (f == oaht_pkg::FnInsert && k != '0)
            planned_keys.push_back(k);
    endfunction

    function automatic logic [PayloadW-1:0] random_payload();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [KeyW-1:0] random_key();
        logic [31:0] word;
        word = $urandom();
        return word[KeyW-1:0];
    endfunction

    // Request driver: present the next pending item after the drawn gap and record
    // the predicted answer at the edge where the block takes the item. Keep valid
    // high across back-to-back items with a single assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.func    <= oaht_pkg::FnInsert;
            req.key     <= '0;
            req.payload <= '0;
            send_gap = 0;
        end
        else
        begin
            offering = req.valid;
            if (req.valid && req.ready)
            begin
                new_lookup.req = in_flight;
                new_lookup.ans = probe_table(in_flight);
                expected_answers.push_back(new_lookup);
                items_accepted <= items_accepted + 1;
                send_gap = pause_cycles(items_accepted, 0);
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pending_requests.size() != 0)
                begin
                    in_flight = pending_requests.pop_front();
                    req.func    <= in_flight.func;
                    req.key     <= in_flight.key;
                    req.payload <= in_flight.payload;
                    offering = 1'b1;
                end
            end
            req.valid <= offering;
        end
    end

    // Response monitor: compare every answer taken with the oldest prediction,
    // then drop ready for the drawn stall. The long hold overrides ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    if (error_count < 10)
                        $display("answer with nothing outstanding: status %0d slot %0d data %h",
                                 rsp.status, rsp.slot, rsp.found_payload);
                    error_count++;
                end
                else
                begin
                    oldest_lookup = expected_answers.pop_front();
                    if (rsp.status !== oldest_lookup.ans.status
                        || rsp.slot !== oldest_lookup.ans.slot
                        || rsp.found_payload !== oldest_lookup.ans.found_payload)
                    begin
                        if (error_count < 10)
                        begin
                            $display("answer %0d (%s key %0d): exp status %0d slot %0d data %h",
                                     answers_seen,
                                     oldest_lookup.req.func == oaht_pkg::FnSearch ?
                                         "search" : "insert",
                                     oldest_lookup.req.key, oldest_lookup.ans.status,
                                     oldest_lookup.ans.slot,
                                     oldest_lookup.ans.found_payload);
                            $display("    got status %0d slot %0d data %h",
                                     rsp.status, rsp.slot, rsp.found_payload);
                        end
                        error_count++;
                    end
                end
                answers_seen <= answers_seen + 1;
                recv_gap = pause_cycles(answers_seen, 1);
            end
            else if (recv_gap != 0)
                recv_gap--;
            rsp.ready <= (recv_gap == 0) && (hold_left == 0);
        end
    end

    // Hold the response side off once for a long stretch while requests keep coming,
    // so the block backs up and drops req.ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_accepted >= HoldAfter)
        begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, expected_answers.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int n;
        int pick;
        rst_n = 1'b0;

        // Directed part. Zero keys on both operations first.
        queue_request(oaht_pkg::FnInsert, '0, '1);
        queue_request(oaht_pkg::FnSearch, '0, '0);
        // Largest key lands in slot 2 with an all-ones payload; smallest key in slot 1.
        queue_request(oaht_pkg::FnInsert, KeyMax, '1);
        queue_request(oaht_pkg::FnInsert, KeyW'(1), '0);
        queue_request(oaht_pkg::FnSearch, KeyMax, '0);
        // Collide on home slot 0, then insert a duplicate: the search must hit the first.
        queue_request(oaht_pkg::FnInsert, KeyW'(19), 64'h0123_4567_89ab_cdef);
        queue_request(oaht_pkg::FnInsert, KeyW'(38), random_payload());
        queue_request(oaht_pkg::FnInsert, KeyW'(19), 64'hfedc_ba98_7654_3210);
        queue_request(oaht_pkg::FnSearch, KeyW'(19), random_payload());
        // Miss that runs into the first empty slot.
        queue_request(oaht_pkg::FnSearch, KeyW'(57), '0);
        // Wrap from the last slot around to the front of the table.
        queue_request(oaht_pkg::FnInsert, KeyW'(18), random_payload());
        queue_request(oaht_pkg::FnInsert, KeyW'(37), random_payload());
        queue_request(oaht_pkg::FnSearch, KeyW'(37), '0);
        // Fill the rest as one long cluster from home slot 6.
        for (n = 0; n < TableSize - 7; n++)
            queue_request(oaht_pkg::FnInsert,
                          KeyW'(6 + 19 * $urandom_range(1, 100000000)),
                          random_payload());
        // Insert into a full table, and a search that probes every slot without a match.
        queue_request(oaht_pkg::FnInsert, KeyW'(25), '1);
        queue_request(oaht_pkg::FnSearch, KeyW'(6), '0);

        // Random part: mostly searches of stored keys at every probe depth, plus
        // misses, rejected inserts and zero keys.
        for (n = 0; n < RandomItems; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_request(oaht_pkg::FnSearch,
                              planned_keys[$urandom_range(0, planned_keys.size() - 1)],
                              random_payload());
            else if (pick < 75)
                queue_request(oaht_pkg::FnSearch, random_key(), random_payload());
            else if (pick < 80)
                queue_request(pick[0] ? oaht_pkg::FnSearch : oaht_pkg::FnInsert, '0,
                              random_payload());
            else
                queue_request(oaht_pkg::FnInsert, random_key(), random_payload());
        end
        total_requests = pending_requests.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to be taken, every answer to arrive, then a quiet tail.
        while (items_accepted != total_requests)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("%0d lookups: %0d stored, %0d refused full, %0d hits, %0d misses, %0d zero keys",
                 total_requests, stored_count, full_count, hit_count, miss_count,
                 zero_key_count);
        $display("response side held off %0d cycles once; %0d mismatches in %0d cycles",
                 HoldCycles, error_count, cycle_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: open_address_hash_table.f
+incdir+hdl
hdl/oaht_pkg.sv
hdl/oaht_ifs.sv
hdl/oaht_hash.sv
hdl/oaht_seq.sv
hdl/oaht_dpath.sv
hdl/open_address_hash_table.sv
tb/open_address_hash_table_test.sv
